@@ src/bps_pkg.sv @@
// Shared types and constants for the bilge pump supervisor.
// Holds event codes, modes, register indexes, status flags and reset values.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    // Width of the ADC sample field on the request channel
    localparam int SAMPLE_W = 12;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Result list of one tick: up to six events plus the closing status
    localparam int EV_DEPTH = 7;
    localparam int EV_IDX_W = $clog2(EV_DEPTH);
    localparam int EV_CNT_W = $clog2(EV_DEPTH + 1);

    typedef enum logic [2:0] {
        EV_STATUS   = 3'd0,
        EV_ZERO     = 3'd1,
        EV_OVER     = 3'd2,
        EV_WATER    = 3'd3,
        EV_SENSOR   = 3'd4,
        EV_TOO_LONG = 3'd5,
        EV_AUTO_OFF = 3'd6
    } ev_code_t;

    typedef enum logic [1:0] {
        MODE_AUTO = 2'd0,
        MODE_ON   = 2'd1,
        MODE_OFF  = 2'd2
    } pump_mode_t;

    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        REG_GAIN       = 3'd0,
        REG_ZERO_LIM   = 3'd1,
        REG_WATER_LIM  = 3'd2,
        REG_OVER_LIM   = 3'd3,
        REG_NORM_INT   = 3'd4,
        REG_FATAL_INT  = 3'd5,
        REG_WFIRST_INT = 3'd6,
        REG_WSECOND_INT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic sensor;
        logic over;
        logic zero;
        logic water;
    } flags_t;

    // Outcome of one current measurement
    typedef struct packed {
        flags_t f;
        logic   ev_water;
        logic   ev_zero;
        logic   ev_over;
    } meas_t;

    // Register reset values
    localparam logic [15:0] RST_GAIN        = 16'd256;
    localparam logic [15:0] RST_ZERO_LIM    = 16'd50;
    localparam logic [15:0] RST_WATER_LIM   = 16'd1000;
    localparam logic [15:0] RST_OVER_LIM    = 16'd5000;
    localparam logic [15:0] RST_NORM_INT    = 16'd3000;
    localparam logic [15:0] RST_FATAL_INT   = 16'd6000;
    localparam logic [15:0] RST_WFIRST_INT  = 16'd600;
    localparam logic [15:0] RST_WSECOND_INT = 16'd1200;

endpackage

`default_nettype wire

@@ src/bps_frame_avg.sv @@
// Frame averager: sums every third ADC sample of a frame and latches the mean.
// Divides by the pick count with an exact reciprocal multiply.
// Depends on bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_frame_avg #(
    parameter int FRAME_LEN   = 100,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         sample_go,
    input  wire logic [bps_pkg::SAMPLE_W-1:0] sample,
    output logic      [bps_pkg::SAMPLE_W-1:0] avg
);
    import bps_pkg::*;

    localparam int USE_BITS   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int PICK_COUNT = (FRAME_LEN + 1) / 3;
    localparam int SUM_W      = USE_BITS + $clog2(PICK_COUNT + 1);
    localparam int SH         = SUM_W + $clog2(PICK_COUNT);
    localparam int PROD_W     = SUM_W + SH + 1;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam logic [SH:0] RECIP =
        (SH + 1)'(((64'd1 << SH) + 64'(PICK_COUNT) - 64'd1) / 64'(PICK_COUNT));
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    // phase is (position + 2) mod 3; a sample is picked in phase zero
    localparam logic [1:0] PH_PICK = 2'd0;
    localparam logic [1:0] PH_LAST = 2'd2;

    logic [POS_W-1:0]    pos_reg;
    logic [1:0]          phase_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [USE_BITS-1:0] avg_reg;

    logic [USE_BITS-1:0] s;
    logic                pick;
    logic [SUM_W-1:0]    total;
    logic [PROD_W-1:0]   prod;
    logic                frame_end;

    assign s         = sample[USE_BITS-1:0];
    assign pick      = (phase_reg == PH_PICK);
    assign total     = sum_reg + (pick ? SUM_W'(s) : '0);
    assign prod      = PROD_W'(total) * PROD_W'(RECIP);
    assign frame_end = (pos_reg == LAST_POS);
    assign avg       = SAMPLE_W'(avg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_LAST;
            sum_reg   <= '0;
            avg_reg   <= '0;
        end
        else if (sample_go)
        begin
            if (frame_end)
            begin
                avg_reg   <= prod[SH +: USE_BITS];
                sum_reg   <= '0;
                pos_reg   <= '0;
                phase_reg <= PH_LAST;
            end
            else
            begin
                sum_reg   <= total;
                pos_reg   <= pos_reg + POS_W'(1);
                phase_reg <= (phase_reg == PH_LAST) ? PH_PICK : phase_reg + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/bilge_pump_supervisor_core.sv @@
// Top level of the bilge pump supervisor: request stage, tick supervisor,
// configuration registers and the result list that drains one item a cycle while out_ready is high.
// Depends on bps_pkg and bps_frame_avg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | input     | in_valid / in_ready   | req_type, pump_mode, sensor_wet,
//          |           |                       | sample_value
//  out     | output    | out_valid / out_ready | event_code, pump_drive, current_ma,
//          |           |                       | last_of_tick
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Flow: a request is taken into the request register and processed from there; one
// request per cycle is sustained while no tick stalls. Sample requests give no results.
// A tick loads its 1 to 7 results into the result list register, which drains one
// result per cycle while out_ready is high.
// Stalls: a tick waits in the request register until the previous tick's list is
// empty or its last result leaves in that cycle; requests behind it hold meanwhile.
// Reset: rst_n clears all control state and loads register reset values.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module bilge_pump_supervisor_core #(
    parameter int FRAME_LEN   = 100,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           req_type,
    input  wire logic [1:0]                     pump_mode,
    input  wire logic                           sensor_wet,
    input  wire logic [bps_pkg::SAMPLE_W-1:0]   sample_value,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          event_code,
    output logic                                pump_drive,
    output logic [15:0]                         current_ma,
    output logic                                last_of_tick,
    // configuration channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bps_pkg::*;

    // Classify one current reading against the limits and update the flags
    function automatic meas_t measure(flags_t f_in, logic [15:0] c,
                                      logic [15:0] zl, logic [15:0] wl,
                                      logic [15:0] ol);
        meas_t m;
        m          = '0;
        m.f        = f_in;
        if (c >= wl && c < ol)
        begin
            m.f.water  = 1'b1;
            m.ev_water = 1'b1;
        end
        else
        begin
            m.f.water = 1'b0;
        end
        if (c <= zl)
        begin
            m.f.zero  = 1'b1;
            m.ev_zero = 1'b1;
        end
        else if (c >= ol)
        begin
            m.f.over  = 1'b1;
            m.ev_over = 1'b1;
        end
        else
        begin
            m.f.zero = 1'b0;
            m.f.over = 1'b0;
        end
        return m;
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [15:0] gain_reg, zlim_reg, wlim_reg, olim_reg;
    logic [15:0] norm_int_reg, fatal_int_reg, wfirst_int_reg, wsecond_int_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= RST_GAIN;
            zlim_reg        <= RST_ZERO_LIM;
            wlim_reg        <= RST_WATER_LIM;
            olim_reg        <= RST_OVER_LIM;
            norm_int_reg    <= RST_NORM_INT;
            fatal_int_reg   <= RST_FATAL_INT;
            wfirst_int_reg  <= RST_WFIRST_INT;
            wsecond_int_reg <= RST_WSECOND_INT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN:        gain_reg        <= cfg_data;
                REG_ZERO_LIM:    zlim_reg        <= cfg_data;
                REG_WATER_LIM:   wlim_reg        <= cfg_data;
                REG_OVER_LIM:    olim_reg        <= cfg_data;
                REG_NORM_INT:    norm_int_reg    <= cfg_data;
                REG_FATAL_INT:   fatal_int_reg   <= cfg_data;
                REG_WFIRST_INT:  wfirst_int_reg  <= cfg_data;
                REG_WSECOND_INT: wsecond_int_reg <= cfg_data;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Request register
    // ---------------------------------------------------------------------
    logic                in_vld_reg;
    logic                req_type_reg;
    logic [1:0]          mode_reg;
    logic                wet_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic [EV_CNT_W-1:0] rem_reg;
    logic                list_free;
    logic                sample_go;
    logic                tick_go;

    // The list can take a new tick when empty or when its last result leaves now
    assign list_free = (rem_reg == '0) || (rem_reg == EV_CNT_W'(1) && out_ready);
    assign sample_go = in_vld_reg && (req_type_reg == REQ_SAMPLE);
    assign tick_go   = in_vld_reg && (req_type_reg == REQ_TICK) && list_free;
    assign in_ready  = !in_vld_reg || sample_go || tick_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    // Payload of the request register: hold until the next request is taken
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_type_reg <= req_type;
            mode_reg     <= pump_mode;
            wet_reg      <= sensor_wet;
            sample_reg   <= sample_value;
        end
    end

    // ---------------------------------------------------------------------
    // Sample frame averaging
    // ---------------------------------------------------------------------
    logic [SAMPLE_W-1:0] avg;

    bps_frame_avg #(
        .FRAME_LEN   (FRAME_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_frame_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_go (sample_go),
        .sample    (sample_reg),
        .avg       (avg)
    );

    // ---------------------------------------------------------------------
    // Tick supervisor
    // ---------------------------------------------------------------------
    logic [15:0]  last_current_reg, ticks_reg, act_int_reg;
    flags_t       flags_reg;
    logic [1:0]   leak_reg, oc_reg;
    logic         dead_reg, started_reg;

    // Milliamps: Q8 gain on the latched average, saturated to 16 bits
    logic [SAMPLE_W+15:0] cur_prod;
    logic [SAMPLE_W+7:0]  cur_shift;
    logic [15:0]          cur_ma;

    assign cur_prod  = (SAMPLE_W + 16)'(avg) * (SAMPLE_W + 16)'(gain_reg);
    assign cur_shift = cur_prod[SAMPLE_W+15:8];
    assign cur_ma    = (|cur_shift[SAMPLE_W+7:16]) ? 16'hFFFF : cur_shift[15:0];

    meas_t              m0, m1;
    flags_t             fl;
    logic [15:0]        ticks_inc, ticks_n, act_n, cur_n;
    logic [1:0]         leak_n, oc_n;
    logic               dead_n, drive_n, on;
    logic               mode_meas;
    ev_code_t           list [EV_DEPTH];
    logic [EV_IDX_W-1:0] n;
    logic [EV_CNT_W-1:0] list_cnt;

    always_comb
    begin
        fl      = flags_reg;
        leak_n  = leak_reg;
        oc_n    = oc_reg;
        dead_n  = dead_reg;
        act_n   = act_int_reg;
        cur_n   = last_current_reg;
        drive_n = 1'b0;
        on      = 1'b0;
        n       = '0;
        for (int k = 0; k < EV_DEPTH; k++)
            list[k] = EV_STATUS;

        // Start-up check on the first tick: flags, current and events only
        m0 = measure(fl, cur_ma, zlim_reg, wlim_reg, olim_reg);
        if (!started_reg)
        begin
            fl    = m0.f;
            cur_n = cur_ma;
            if (m0.ev_water)
            begin
                list[n] = EV_WATER;
                n = n + EV_IDX_W'(1);
            end
            if (m0.ev_zero)
            begin
                list[n] = EV_ZERO;
                n = n + EV_IDX_W'(1);
            end
            if (m0.ev_over)
            begin
                list[n] = EV_OVER;
                n = n + EV_IDX_W'(1);
            end
        end

        // Interval count, saturating
        ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
        ticks_n   = ticks_inc;
        mode_meas = (mode_reg == MODE_AUTO) || (mode_reg == MODE_ON);

        m1 = measure(fl, cur_ma, zlim_reg, wlim_reg, olim_reg);
        if (mode_meas && ticks_inc >= act_int_reg)
        begin
            ticks_n = '0;
            if (!dead_reg)
            begin
                fl    = m1.f;
                cur_n = cur_ma;
                if (m1.ev_water)
                begin
                    list[n] = EV_WATER;
                    n = n + EV_IDX_W'(1);
                end
                if (m1.ev_zero)
                begin
                    list[n] = EV_ZERO;
                    n = n + EV_IDX_W'(1);
                end
                if (m1.ev_over)
                begin
                    list[n] = EV_OVER;
                    n = n + EV_IDX_W'(1);
                end
                if (fl.water && leak_n < 2'd2)
                    leak_n = leak_n + 2'd1;
                if (fl.over)
                begin
                    if (oc_n < 2'd2)
                        oc_n = oc_n + 2'd1;
                end
                else
                begin
                    oc_n = '0;
                end
            end
        end

        // Discrete water sensor
        fl.sensor = wet_reg;
        if (wet_reg)
        begin
            list[n] = EV_SENSOR;
            n = n + EV_IDX_W'(1);
        end

        // Pump drive and next measurement interval
        case (mode_reg)
            MODE_ON:
            begin
                drive_n = 1'b1;
            end
            MODE_AUTO:
            begin
                on = fl.water;
                if (oc_n == 2'd1)
                begin
                    act_n = fatal_int_reg;
                end
                else if (oc_n >= 2'd2)
                begin
                    oc_n    = 2'd2;
                    on      = 1'b0;
                    dead_n  = 1'b1;
                    list[n] = EV_AUTO_OFF;
                    n = n + EV_IDX_W'(1);
                end
                else
                begin
                    act_n = norm_int_reg;
                end
                if (on)
                begin
                    drive_n = 1'b1;
                    if (leak_n == 2'd1)
                    begin
                        act_n = wfirst_int_reg;
                    end
                    else if (leak_n >= 2'd2)
                    begin
                        leak_n  = 2'd2;
                        act_n   = wsecond_int_reg;
                        list[n] = EV_TOO_LONG;
                        n = n + EV_IDX_W'(1);
                    end
                    else
                    begin
                        act_n = norm_int_reg;
                    end
                end
                else
                begin
                    drive_n = 1'b0;
                    leak_n  = '0;
                end
            end
            default:
            begin
                // forced off, and the unused mode code
                drive_n = 1'b0;
            end
        endcase

        // Close the list with the status result
        list[n]  = EV_STATUS;
        list_cnt = EV_CNT_W'(n) + EV_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_current_reg <= '0;
            ticks_reg        <= '0;
            act_int_reg      <= RST_NORM_INT;
            flags_reg        <= '0;
            leak_reg         <= '0;
            oc_reg           <= '0;
            dead_reg         <= 1'b0;
            started_reg      <= 1'b0;
        end
        else if (tick_go)
        begin
            last_current_reg <= cur_n;
            ticks_reg        <= ticks_n;
            act_int_reg      <= act_n;
            flags_reg        <= fl;
            leak_reg         <= leak_n;
            oc_reg           <= oc_n;
            dead_reg         <= dead_n;
            started_reg      <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Result list: load on a tick, advance when out_ready accepts a result, not an input request
    // ---------------------------------------------------------------------
    ev_code_t ev_reg [EV_DEPTH];
    logic     drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else if (tick_go)
            rem_reg <= list_cnt;
        else if (out_valid && out_ready)
            rem_reg <= rem_reg - EV_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            for (int k = 0; k < EV_DEPTH; k++)
                ev_reg[k] <= list[k];
            drive_reg <= drive_n;
        end
        else if (out_valid && out_ready)
        begin
            for (int k = 0; k < EV_DEPTH - 1; k++)
                ev_reg[k] <= ev_reg[k + 1];
        end
    end

    assign out_valid    = (rem_reg != '0);
    assign event_code   = ev_reg[0];
    assign pump_drive   = drive_reg;
    assign current_ma   = last_current_reg;
    assign last_of_tick = (rem_reg == EV_CNT_W'(1));

`ifndef SYNTH
    // Only reset clears a dead pump
    a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |=> dead_reg)
        else $error("pump dead latch cleared without reset");

    // A tick only loads the list when it is empty or only the previous tick's closing result is leaving
    a_tick_room: assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |-> (rem_reg == '0 || (rem_reg == EV_CNT_W'(1) && out_ready)))
        else $error("tick loaded over pending results");

    // Both counters saturate at two
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        leak_reg != 2'd3 && oc_reg != 2'd3)
        else $error("leak or overcurrent count out of range");

    // The request side stalls only behind a tick waiting on the result list
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_vld_reg && req_type_reg == REQ_TICK && rem_reg != '0))
        else $error("request stall without a waiting tick");

    // A dead pump in auto mode is never driven
    a_dead_off: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_go && dead_reg && mode_reg == MODE_AUTO) |=> !pump_drive)
        else $error("dead pump driven in auto mode");
`endif

endmodule

`default_nettype wire
